>>> sv/ogcs_pkg.sv
// ----------------------------------------------------------------------------
// OLED glyph command sequencer package
// Shared request codes, display command bytes and controller/datapath types.
// ----------------------------------------------------------------------------
package ogcs_pkg;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_DRAW      = 2'd0;
	localparam logic [1:0] REQ_LOAD      = 2'd1;
	localparam logic [1:0] REQ_POWER_ON  = 2'd2;
	localparam logic [1:0] REQ_POWER_OFF = 2'd3;

	// Display controller command bytes.
	localparam logic [7:0] CMD_CHARGE_PUMP = 8'h8D;
	localparam logic [7:0] CMD_PUMP_ON     = 8'h14;
	localparam logic [7:0] CMD_PUMP_OFF    = 8'h10;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
	localparam logic [7:0] CMD_PAGE        = 8'hB0;
	localparam logic [7:0] CMD_COL_HI      = 8'h10;
	localparam logic [7:0] CMD_COL_LO_SET  = 8'h01;

	// Step counts and sizes of one request's byte run.
	localparam int          STEP_W         = 6;
	localparam logic [5:0]  LAST_STEP_PWR  = 6'd2;
	localparam logic [5:0]  LAST_STEP_NARROW = 6'd21;
	localparam logic [5:0]  LAST_STEP_WIDE = 6'd37;
	localparam logic [5:0]  CURSOR_LEN     = 6'd3;
	localparam logic [5:0]  HALF_NARROW    = 6'd8;
	localparam logic [5:0]  HALF_WIDE      = 6'd16;
	localparam int          GLYPH_BASE_W   = 13;
	localparam logic [1:0]  REDUCE_FIRST   = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       reduce;
		logic [1:0] red_shift;
		logic       write;
		logic       issue;
	} ogcs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_load;
		logic issue_ok;
		logic last_step;
	} ogcs_sts_t;

endpackage

>>> sv/ogcs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ogcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/ogcs_ctrl.sv
// ----------------------------------------------------------------------------
// OLED glyph sequencer controller
// State machine that accepts requests, steps the address reduction, writes
// font bytes and paces the byte issue of the datapath.
// ----------------------------------------------------------------------------
module ogcs_ctrl import ogcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [1:0] req_type,
	input  ogcs_sts_t sts,
	output ogcs_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_WRITE,
		ST_RUN
	} state_t;

	state_t     state_q;
	logic [1:0] red_cnt_q;

	// Command decode from the current state.
	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.reduce    = (state_q == ST_REDUCE);
		cmd.red_shift = red_cnt_q;
		cmd.write     = (state_q == ST_WRITE);
		cmd.issue     = (state_q == ST_RUN) && sts.issue_ok;
	end

	assign in_stall = (state_q != ST_IDLE);

	// State register and reduction step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			red_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						red_cnt_q <= REDUCE_FIRST;
						if (req_type == REQ_DRAW || req_type == REQ_LOAD) begin
							state_q <= ST_REDUCE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_REDUCE: begin
					red_cnt_q <= red_cnt_q - 2'd1;
					if (red_cnt_q == 2'd0) begin
						state_q <= sts.is_load ? ST_WRITE : ST_RUN;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_RUN: begin
					if (cmd.issue && sts.last_step) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/ogcs_dpath.sv
// ----------------------------------------------------------------------------
// OLED glyph sequencer datapath
// Holds the request, reduces font addresses into the store, owns the font
// RAM and forms each command or data byte into a two-stage output path.
// ----------------------------------------------------------------------------
module ogcs_dpath import ogcs_pkg::*; #(
	parameter int FONT_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic [1:0] req_type,
	input  logic [7:0] pos_x,
	input  logic [2:0] page_y,
	input  logic [7:0] glyph_index,
	input  logic       wide,
	input  logic       inverse,
	input  logic [11:0] font_addr,
	input  logic [7:0] font_byte,
	input  ogcs_cmd_t  cmd,
	output ogcs_sts_t  sts,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last
);

	localparam int AW = $clog2(FONT_BYTES);
	localparam int RW = AW + 4;
	localparam logic [RW-1:0] FONT_SZ   = RW'(FONT_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(FONT_BYTES - 1);

	logic [7:0]        col_ofs_q;
	logic [1:0]        type_q;
	logic [2:0]        page_q;
	logic              wide_q;
	logic              inv_q;
	logic [7:0]        col_q;
	logic [7:0]        wr_byte_q;
	logic [RW-1:0]     red_q;
	logic [STEP_W-1:0] step_q;

	logic              s1_vld_s1;
	logic [7:0]        s1_byte_s1;
	logic              s1_data_s1;
	logic              s1_last_s1;
	logic              s1_inv_s1;

	logic              out_vld_q;
	logic [7:0]        out_byte_q;
	logic              is_data_q;
	logic              last_q;

	logic [GLYPH_BASE_W-1:0] glyph_base;
	logic [RW-1:0]     red_sub;
	logic [AW-1:0]     addr;
	logic [5:0]        half_len;
	logic [5:0]        last_step;
	logic [5:0]        ci_full;
	logic [1:0]        ci;
	logic              step_cur2;
	logic              step_data;
	logic [3:0]        page_sel;
	logic [7:0]        step_byte;
	logic              s1_move;
	logic [7:0]        rdata;

	// Column offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_ofs_q <= 8'd2;
		end else if (cfg_wr_en) begin
			col_ofs_q <= cfg_wr_data;
		end
	end

	// First store address of a glyph.
	assign glyph_base = wide ? {glyph_index, 5'b0} : {1'b0, glyph_index, 4'b0};
	assign red_sub    = FONT_SZ << cmd.red_shift;
	assign addr       = red_q[AW-1:0];

	// Request fields, address reduction and address stepping.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			type_q    <= req_type;
			page_q    <= page_y;
			wide_q    <= wide;
			inv_q     <= inverse;
			col_q     <= pos_x + col_ofs_q;
			wr_byte_q <= font_byte;
			step_q    <= '0;
			if (req_type == REQ_LOAD) begin
				red_q <= {{(RW-12){1'b0}}, font_addr};
			end else begin
				red_q <= {{(RW-GLYPH_BASE_W){1'b0}}, glyph_base};
			end
		end else if (cmd.reduce) begin
			if (red_q >= red_sub) begin
				red_q <= red_q - red_sub;
			end
		end else if (cmd.issue) begin
			step_q <= step_q + 6'd1;
			if (step_data) begin
				red_q <= (addr == LAST_ADDR) ? '0 : red_q + RW'(1);
			end
		end
	end

	// Decode of the current step into a command byte or a data read.
	always_comb begin
		half_len  = wide_q ? HALF_WIDE : HALF_NARROW;
		ci_full   = step_q - (CURSOR_LEN + half_len);
		step_cur2 = (step_q >= CURSOR_LEN + half_len) &&
			(step_q < CURSOR_LEN + CURSOR_LEN + half_len);
		step_data = 1'b0;
		ci        = step_cur2 ? ci_full[1:0] : step_q[1:0];
		page_sel  = {1'b0, page_q} + {3'b0, step_cur2};
		step_byte = '0;
		last_step = LAST_STEP_PWR;
		case (type_q)
			REQ_POWER_ON: begin
				case (step_q[1:0])
					2'd0:    step_byte = CMD_CHARGE_PUMP;
					2'd1:    step_byte = CMD_PUMP_ON;
					default: step_byte = CMD_DISPLAY_ON;
				endcase
			end
			REQ_POWER_OFF: begin
				case (step_q[1:0])
					2'd0:    step_byte = CMD_CHARGE_PUMP;
					2'd1:    step_byte = CMD_PUMP_OFF;
					default: step_byte = CMD_DISPLAY_OFF;
				endcase
			end
			default: begin
				last_step = wide_q ? LAST_STEP_WIDE : LAST_STEP_NARROW;
				step_data = !(step_q < CURSOR_LEN) && !step_cur2;
				case (ci)
					2'd0:    step_byte = CMD_PAGE + {4'h0, page_sel};
					2'd1:    step_byte = CMD_COL_HI | {4'h0, col_q[7:4]};
					default: step_byte = {4'h0, col_q[3:0]} | CMD_COL_LO_SET;
				endcase
			end
		endcase
	end

	// Font store.
	ogcs_ram #(
		.WIDTH(8),
		.DEPTH(FONT_BYTES)
	) u_font_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (addr),
		.wdata (wr_byte_q),
		.re    (cmd.issue && step_data),
		.raddr (addr),
		.rdata (rdata)
	);

	// Issue stage: waits here for the font read to land.
	assign s1_move = s1_vld_s1 && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else if (cmd.issue) begin
			s1_vld_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			s1_byte_s1 <= step_byte;
			s1_data_s1 <= step_data;
			s1_last_s1 <= (step_q == last_step);
			s1_inv_s1  <= inv_q;
		end
	end

	// Output register holding the byte until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			if (s1_data_s1) begin
				out_byte_q <= s1_inv_s1 ? ~rdata : rdata;
			end else begin
				out_byte_q <= s1_byte_s1;
			end
			is_data_q <= s1_data_s1;
			last_q    <= s1_last_s1;
		end
	end

	assign out_valid = out_vld_q;
	assign out_byte  = out_byte_q;
	assign is_data   = is_data_q;
	assign last      = last_q;

	// Status back to the controller.
	assign sts.is_load   = (type_q == REQ_LOAD);
	assign sts.issue_ok  = !s1_vld_s1 || s1_move;
	assign sts.last_step = (step_q == last_step);

endmodule

>>> sv/oled_glyph_command_sequencer.sv
// ----------------------------------------------------------------------------
// OLED glyph command sequencer
// Turns draw, font load and power requests into the command and data byte
// stream of a page-mode OLED controller.
// ----------------------------------------------------------------------------
// Throughput: one output byte per cycle while the output is not stalled.
// A request is accepted, draws and font loads then reduce the address into
// the store, and each request then issues its bytes or, for a font load,
// writes the store; the next request is taken once the last byte has issued.
// An issued byte passes the issue stage, then the output register, to become valid.
// Reset clears control state and sets the column offset to 2, not the font store.
module oled_glyph_command_sequencer import ogcs_pkg::*; #(
	parameter int FONT_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] pos_x,
	input  logic [2:0] page_y,
	input  logic [7:0] glyph_index,
	input  logic       wide,
	input  logic       inverse,
	input  logic [11:0] font_addr,
	input  logic [7:0] font_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last
);

	ogcs_cmd_t cmd;
	ogcs_sts_t sts;

	// Request sequencing.
	ogcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Address, font store and byte formation.
	ogcs_dpath #(
		.FONT_BYTES(FONT_BYTES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.page_y      (page_y),
		.glyph_index (glyph_index),
		.wide        (wide),
		.inverse     (inverse),
		.font_addr   (font_addr),
		.font_byte   (font_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.is_data     (is_data),
		.last        (last)
	);

endmodule
